@@ sv/sbis_pkg.sv @@
// Shared types, codes and the control program of the ordered sequence store.
package sbis_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_INSERT  = 2'd1,
    CMD_SORT    = 2'd2,
    CMD_DISPLAY = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOB   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  localparam int POS_W  = 6;
  localparam int ELEM_W = 32;
  localparam int UPC_W  = 5;
  typedef logic [UPC_W-1:0] upc_t;

  // Program addresses.
  localparam upc_t U_IDLE      = 5'd0;
  localparam upc_t U_APP_CHK   = 5'd1;
  localparam upc_t U_APP_PUT   = 5'd2;
  localparam upc_t U_INS_CHK   = 5'd3;
  localparam upc_t U_INS_FULL  = 5'd4;
  localparam upc_t U_INS_LOOP  = 5'd5;
  localparam upc_t U_INS_SHIFT = 5'd6;
  localparam upc_t U_INS_PUT   = 5'd7;
  localparam upc_t U_SRT_CHK   = 5'd8;
  localparam upc_t U_SRT_OUTER = 5'd9;
  localparam upc_t U_SRT_LOAD  = 5'd10;
  localparam upc_t U_SRT_INNER = 5'd11;
  localparam upc_t U_SRT_CMP   = 5'd12;
  localparam upc_t U_SRT_NEXT  = 5'd13;
  localparam upc_t U_DSP_CHK   = 5'd14;
  localparam upc_t U_DSP_READ  = 5'd15;
  localparam upc_t U_DSP_EMIT  = 5'd16;
  localparam upc_t U_DSP_END   = 5'd17;
  localparam upc_t U_R_OK      = 5'd18;
  localparam upc_t U_R_OOB     = 5'd19;
  localparam upc_t U_R_FULL    = 5'd20;
  localparam upc_t U_R_EMPTY   = 5'd21;
  localparam upc_t U_LAST      = 5'd21;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_DISPATCH,
    C_FULL,
    C_OOB,
    C_EMPTY,
    C_I_LE_P1,
    C_I_DONE,
    C_I_MORE,
    C_J_DONE
  } cond_t;

  typedef enum logic [2:0] {I_HOLD, I_ZERO, I_COUNT, I_INC, I_DEC} i_op_t;
  typedef enum logic [1:0] {J_HOLD, J_I1, J_INC} j_op_t;
  typedef enum logic [1:0] {RD_NONE, RD_I, RD_IM1, RD_J} rd_t;
  typedef enum logic [2:0] {WR_NONE, WR_APPEND, WR_SHIFT, WR_INSERT, WR_SWAP, WR_MIN} wr_t;
  typedef enum logic [1:0] {A_HOLD, A_RDATA, A_SWAP} acc_t;

  typedef struct packed {
    logic    take_in;
    logic    emit;
    logic    disp;
    status_t st;
    cond_t   cond;
    upc_t    target;
    i_op_t   i_op;
    j_op_t   j_op;
    rd_t     rd;
    wr_t     wr;
    acc_t    acc;
    logic    cnt_inc;
  } uword_t;

  typedef struct packed {
    uword_t w;
    logic   go;
  } seq_ctrl_t;

  typedef struct packed {
    logic     in_valid;
    command_t in_cmd;
    logic     out_free;
    logic     full;
    logic     oob;
    logic     empty;
    logic     i_le_p1;
    logic     i_done;
    logic     j_done;
  } dp_flags_t;

  localparam uword_t UW_NOP = '{
    take_in: 1'b0, emit: 1'b0, disp: 1'b0, st: ST_OK, cond: C_NEVER,
    target: U_IDLE, i_op: I_HOLD, j_op: J_HOLD, rd: RD_NONE, wr: WR_NONE,
    acc: A_HOLD, cnt_inc: 1'b0
  };

  function automatic upc_t entry_of(command_t cmd);
    upc_t e;
    case (cmd)
      CMD_APPEND: e = U_APP_CHK;
      CMD_INSERT: e = U_INS_CHK;
      CMD_SORT:   e = U_SRT_CHK;
      default:    e = U_DSP_CHK;
    endcase
    return e;
  endfunction

  // The control store.
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    w = UW_NOP;
    case (a)
      U_IDLE: begin
        w.take_in = 1'b1;
        w.cond    = C_DISPATCH;
      end
      U_APP_CHK: begin
        w.cond   = C_FULL;
        w.target = U_R_FULL;
      end
      U_APP_PUT: begin
        w.wr      = WR_APPEND;
        w.cnt_inc = 1'b1;
        w.cond    = C_ALWAYS;
        w.target  = U_R_OK;
      end
      U_INS_CHK: begin
        w.cond   = C_OOB;
        w.target = U_R_OOB;
      end
      U_INS_FULL: begin
        w.cond   = C_FULL;
        w.target = U_R_FULL;
        w.i_op   = I_COUNT;
      end
      U_INS_LOOP: begin
        w.cond   = C_I_LE_P1;
        w.target = U_INS_PUT;
        w.rd     = RD_IM1;
      end
      U_INS_SHIFT: begin
        w.wr     = WR_SHIFT;
        w.i_op   = I_DEC;
        w.cond   = C_ALWAYS;
        w.target = U_INS_LOOP;
      end
      U_INS_PUT: begin
        w.wr      = WR_INSERT;
        w.cnt_inc = 1'b1;
        w.cond    = C_ALWAYS;
        w.target  = U_R_OK;
      end
      U_SRT_CHK: begin
        w.cond   = C_EMPTY;
        w.target = U_R_EMPTY;
        w.i_op   = I_ZERO;
      end
      U_SRT_OUTER: begin
        w.cond   = C_I_DONE;
        w.target = U_R_OK;
        w.rd     = RD_I;
        w.j_op   = J_I1;
      end
      U_SRT_LOAD: begin
        w.acc = A_RDATA;
      end
      U_SRT_INNER: begin
        w.cond   = C_J_DONE;
        w.target = U_SRT_NEXT;
        w.rd     = RD_J;
      end
      U_SRT_CMP: begin
        w.wr     = WR_SWAP;
        w.acc    = A_SWAP;
        w.j_op   = J_INC;
        w.cond   = C_ALWAYS;
        w.target = U_SRT_INNER;
      end
      U_SRT_NEXT: begin
        w.wr     = WR_MIN;
        w.i_op   = I_INC;
        w.cond   = C_ALWAYS;
        w.target = U_SRT_OUTER;
      end
      U_DSP_CHK: begin
        w.cond   = C_EMPTY;
        w.target = U_R_EMPTY;
        w.i_op   = I_ZERO;
      end
      U_DSP_READ: begin
        w.rd = RD_I;
      end
      U_DSP_EMIT: begin
        w.emit   = 1'b1;
        w.disp   = 1'b1;
        w.st     = ST_OK;
        w.i_op   = I_INC;
        w.cond   = C_I_MORE;
        w.target = U_DSP_READ;
      end
      U_R_OK: begin
        w.emit   = 1'b1;
        w.st     = ST_OK;
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
      U_R_OOB: begin
        w.emit   = 1'b1;
        w.st     = ST_OOB;
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
      U_R_FULL: begin
        w.emit   = 1'b1;
        w.st     = ST_FULL;
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
      U_R_EMPTY: begin
        w.emit   = 1'b1;
        w.st     = ST_EMPTY;
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
      default: begin
        // Display end and unused addresses return to the idle step.
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ sv/sbis_ifs.sv @@
// Request and response channel interfaces of the ordered sequence store.
interface sbis_req_if;
  logic                                 valid;
  logic                                 ready;
  sbis_pkg::command_t                   command;
  logic [sbis_pkg::POS_W-1:0]           position;
  logic signed [sbis_pkg::ELEM_W-1:0]   value;

  modport source (output valid, command, position, value, input ready);
  modport sink (input valid, command, position, value, output ready);
endinterface

interface sbis_rsp_if;
  logic                                 valid;
  logic                                 ready;
  sbis_pkg::status_t                    status;
  logic signed [sbis_pkg::ELEM_W-1:0]   element;
  logic [sbis_pkg::POS_W-1:0]           element_index;
  logic                                 last;

  modport source (output valid, status, element, element_index, last, input ready);
  modport sink (input valid, status, element, element_index, last, output ready);
endinterface

@@ sv/sbis_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jump logic.
module sbis_seq (
  input  logic                clk,
  input  logic                rst,
  input  sbis_pkg::dp_flags_t flags,
  output sbis_pkg::seq_ctrl_t ctrl
);

  sbis_pkg::upc_t   upc;
  sbis_pkg::upc_t   upc_next;
  sbis_pkg::uword_t w;
  logic             go;
  logic             taken;

  assign w = sbis_pkg::ucode(upc);

  // A step that takes a request waits for one; a step that emits waits for room.
  always_comb begin
    if (w.take_in) begin
      go = flags.in_valid;
    end else if (w.emit) begin
      go = flags.out_free;
    end else begin
      go = 1'b1;
    end
  end

  always_comb begin
    case (w.cond)
      sbis_pkg::C_ALWAYS:  taken = 1'b1;
      sbis_pkg::C_FULL:    taken = flags.full;
      sbis_pkg::C_OOB:     taken = flags.oob;
      sbis_pkg::C_EMPTY:   taken = flags.empty;
      sbis_pkg::C_I_LE_P1: taken = flags.i_le_p1;
      sbis_pkg::C_I_DONE:  taken = flags.i_done;
      sbis_pkg::C_I_MORE:  taken = !flags.i_done;
      sbis_pkg::C_J_DONE:  taken = flags.j_done;
      default:             taken = 1'b0;
    endcase
  end

  always_comb begin
    if (!go) begin
      upc_next = upc;
    end else if (w.cond == sbis_pkg::C_DISPATCH) begin
      upc_next = sbis_pkg::entry_of(flags.in_cmd);
    end else if (taken) begin
      upc_next = w.target;
    end else begin
      upc_next = upc + sbis_pkg::upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= sbis_pkg::U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  assign ctrl.w  = w;
  assign ctrl.go = go;

  a_upc_in_program: assert property (@(posedge clk) disable iff (rst)
    upc <= sbis_pkg::U_LAST)
    else $error("step counter left the program");

endmodule

@@ sv/sbis_dpath.sv @@
// Datapath: element memory, loop indices, count, compare unit and response register.
module sbis_dpath #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  sbis_req_if.sink            req,
  sbis_rsp_if.source          rsp,
  input  sbis_pkg::seq_ctrl_t ctrl,
  output sbis_pkg::dp_flags_t flags
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > sbis_pkg::POS_W) ? CW : sbis_pkg::POS_W) + 1;

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];

  logic [sbis_pkg::POS_W-1:0]   pos;
  logic signed [DATA_WIDTH-1:0] val;
  logic [CW-1:0]                count;
  logic [CW-1:0]                i;
  logic [CW-1:0]                j;
  logic signed [DATA_WIDTH-1:0] acc;
  logic signed [DATA_WIDTH-1:0] rdata;

  logic                               out_valid;
  sbis_pkg::status_t                  out_status;
  logic signed [sbis_pkg::ELEM_W-1:0] out_element;
  logic [sbis_pkg::POS_W-1:0]         out_index;
  logic                               out_last;

  sbis_pkg::uword_t w;
  logic             go;
  logic             accept;
  logic             out_free;
  logic             gt;
  logic [CMPW-1:0]  pos_p1;
  logic [CW-1:0]    i_m1;
  logic             we;
  logic [AW-1:0]    waddr;
  logic signed [DATA_WIDTH-1:0] wdata;
  logic             re;
  logic [AW-1:0]    raddr;

  assign w        = ctrl.w;
  assign go       = ctrl.go;
  assign req.ready = w.take_in;
  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign gt       = acc > rdata;
  assign pos_p1   = CMPW'(pos) + CMPW'(1);
  assign i_m1     = i - CW'(1);

  assign flags.in_valid = req.valid;
  assign flags.in_cmd   = req.command;
  assign flags.out_free = out_free;
  assign flags.full     = (count == CW'(DEPTH));
  assign flags.oob      = (CMPW'(pos) >= CMPW'(count));
  assign flags.empty    = (count == '0);
  assign flags.i_le_p1  = (CMPW'(i) <= pos_p1);
  assign flags.i_done   = ((CMPW'(i) + CMPW'(1)) >= CMPW'(count));
  assign flags.j_done   = (j >= count);

  // Write port select.
  always_comb begin
    we    = 1'b0;
    waddr = i[AW-1:0];
    wdata = acc;
    case (w.wr)
      sbis_pkg::WR_APPEND: begin
        we    = 1'b1;
        waddr = count[AW-1:0];
        wdata = val;
      end
      sbis_pkg::WR_SHIFT: begin
        we    = 1'b1;
        waddr = i[AW-1:0];
        wdata = rdata;
      end
      sbis_pkg::WR_INSERT: begin
        we    = 1'b1;
        waddr = pos_p1[AW-1:0];
        wdata = val;
      end
      sbis_pkg::WR_SWAP: begin
        we    = gt;
        waddr = j[AW-1:0];
        wdata = acc;
      end
      sbis_pkg::WR_MIN: begin
        we    = 1'b1;
        waddr = i[AW-1:0];
        wdata = acc;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Read port select.
  always_comb begin
    case (w.rd)
      sbis_pkg::RD_I: begin
        re    = 1'b1;
        raddr = i[AW-1:0];
      end
      sbis_pkg::RD_IM1: begin
        re    = 1'b1;
        raddr = i_m1[AW-1:0];
      end
      sbis_pkg::RD_J: begin
        re    = 1'b1;
        raddr = j[AW-1:0];
      end
      default: begin
        re    = 1'b0;
        raddr = i[AW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (go && we) begin
      mem[waddr] <= wdata;
    end
    if (go && re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos <= req.position;
      val <= DATA_WIDTH'(req.value);
    end
    if (go) begin
      case (w.i_op)
        sbis_pkg::I_ZERO:  i <= '0;
        sbis_pkg::I_COUNT: i <= count;
        sbis_pkg::I_INC:   i <= i + CW'(1);
        sbis_pkg::I_DEC:   i <= i_m1;
        default:           i <= i;
      endcase
      case (w.j_op)
        sbis_pkg::J_I1:  j <= i + CW'(1);
        sbis_pkg::J_INC: j <= j + CW'(1);
        default:         j <= j;
      endcase
      case (w.acc)
        sbis_pkg::A_RDATA: acc <= rdata;
        sbis_pkg::A_SWAP:  acc <= gt ? rdata : acc;
        default:           acc <= acc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (go && w.cnt_inc) begin
      count <= count + CW'(1);
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && w.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && w.emit) begin
      out_status  <= w.st;
      out_element <= w.disp ? sbis_pkg::ELEM_W'(rdata) : '0;
      out_index   <= w.disp ? sbis_pkg::POS_W'(i) : '0;
      out_last    <= w.disp ? flags.i_done : 1'b1;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.element       = out_element;
  assign rsp.element_index = out_index;
  assign rsp.last          = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + CW'(1)))
    else $error("element count moved by other than one");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (go && w.emit) |-> out_free)
    else $error("response register overwritten");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (go && (w.wr == sbis_pkg::WR_SHIFT)) |-> (i < CW'(DEPTH)))
    else $error("shift write beyond store");

endmodule

@@ sv/sequence_buffer_insert_sort.sv @@
// Top level of the ordered sequence store with insert and exchange sort.
//
// The block keeps up to DEPTH signed values in sequence order and serves one
// request at a time: append, insert behind an index, sort ascending, or display.
// Every request is answered on the response channel; append, insert and sort
// give one response, display gives one per stored element with last set on the
// final one (or one empty status when nothing is stored). All work runs from a
// small control program that steps a memory with separate read and write ports
// (at most one read or one write per cycle, read data registered), so timing
// follows from memory accesses. Insert behind index p moves every element
// behind p, and every element moved costs a read and a write; sort runs a read
// step and a compare step per element pair of the exchange sort. Every step
// that loads a response waits while the response register still holds an
// answer that has not been taken. A new request can be taken in the cycle after
// the previous answer is loaded into the response register (after the display
// end step that follows the final response of a display), even if that answer
// has not yet been taken. Values are kept in DATA_WIDTH bits: a request value
// is sign extended or truncated on the way in and displayed values are sign
// extended or truncated back to 32 bits. The store needs no clearing after
// reset.
module sequence_buffer_insert_sort #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  sbis_req_if.sink   req,
  sbis_rsp_if.source rsp
);

  sbis_pkg::seq_ctrl_t ctrl;
  sbis_pkg::dp_flags_t flags;

  // The sequencer owns the step counter and the program; the datapath owns
  // every stored value and answers back with the flags the jumps test.
  sbis_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  sbis_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .ctrl  (ctrl),
    .flags (flags)
  );

endmodule
